### sv/fly_camera_orientation_step_unit_assert.svh
// Assertion macros for the fly camera step unit
`ifndef FLY_CAMERA_ORIENTATION_STEP_UNIT_ASSERT_SVH
`define FLY_CAMERA_ORIENTATION_STEP_UNIT_ASSERT_SVH
// implication checked every clock, quiet in reset
`define FCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcs check failed");
// next-cycle implication
`define FCS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcs check failed");
`endif

### sv/fcs_pkg.sv
// Shared types, constants and tables for the fly camera step unit
package fcs_pkg;
  localparam int YAW_FULL     = 92160;
  localparam int HALF_TURN    = 46080;
  localparam int QUARTER_TURN = 23040;
  localparam int PITCH_LIMIT  = 22784;
  localparam int YAW_RESET    = 69120;
  localparam int CORDIC_START = 652032874;
  localparam int TRIG_ITER    = 16;
  localparam int VEC_ONE      = 16384;

  localparam logic [1:0] REG_SPEED = 2'd0;
  localparam logic [1:0] REG_SX    = 2'd1;
  localparam logic [1:0] REG_SY    = 2'd2;
  localparam logic [1:0] REG_SZ    = 2'd3;

  localparam logic [2:0] DIR_NONE = 3'd0;
  localparam logic [2:0] DIR_FWD  = 3'd1;
  localparam logic [2:0] DIR_BACK = 3'd2;
  localparam logic [2:0] DIR_UP   = 3'd3;
  localparam logic [2:0] DIR_DOWN = 3'd4;
  localparam logic [2:0] DIR_RGT  = 3'd5;
  localparam logic [2:0] DIR_LEFT = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ANGLE, ST_CORD_Y, ST_CORD_P, ST_MUL, ST_MOVE, ST_OUT
  } fcs_state_t;

  typedef struct packed {
    logic load;
    logic angle;
    logic cord_start_y;
    logic cord_start_p;
    logic cord_step;
    logic cord_done_y;
    logic cord_done_p;
    logic mul_step;
    logic move_step;
    logic out_load;
  } fcs_cmd_t;

  typedef struct packed {
    logic cord_last;
    logic mul_last;
    logic move_last;
  } fcs_sts_t;

  function automatic logic signed [23:0] atan_deg16(input logic [3:0] i);
    case (i)
      4'd0: atan_deg16 = 24'sd2949120;
      4'd1: atan_deg16 = 24'sd1740967;
      4'd2: atan_deg16 = 24'sd919879;
      4'd3: atan_deg16 = 24'sd466945;
      4'd4: atan_deg16 = 24'sd234379;
      4'd5: atan_deg16 = 24'sd117304;
      4'd6: atan_deg16 = 24'sd58666;
      4'd7: atan_deg16 = 24'sd29335;
      4'd8: atan_deg16 = 24'sd14668;
      4'd9: atan_deg16 = 24'sd7334;
      4'd10: atan_deg16 = 24'sd3667;
      4'd11: atan_deg16 = 24'sd1833;
      4'd12: atan_deg16 = 24'sd917;
      4'd13: atan_deg16 = 24'sd458;
      4'd14: atan_deg16 = 24'sd229;
      4'd15: atan_deg16 = 24'sd115;
      default: atan_deg16 = 24'sd0;
    endcase
  endfunction
endpackage

### sv/fcs_ctrl.sv
// Sequencer for the fly camera step unit
module fcs_ctrl
  import fcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     out_busy,
  input  fcs_sts_t sts,
  output logic     idle,
  output fcs_cmd_t cmd
);
  fcs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    idle = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = ST_ANGLE;
        end
      end
      ST_ANGLE: begin
        cmd.angle = 1'b1;
        cmd.cord_start_y = 1'b1;
        state_nxt = ST_CORD_Y;
      end
      ST_CORD_Y: begin
        // last rotation is folded into the final rounding
        if (sts.cord_last) begin
          cmd.cord_done_y = 1'b1;
          cmd.cord_start_p = 1'b1;
          state_nxt = ST_CORD_P;
        end else begin
          cmd.cord_step = 1'b1;
        end
      end
      ST_CORD_P: begin
        if (sts.cord_last) begin
          cmd.cord_done_p = 1'b1;
          state_nxt = ST_MUL;
        end else begin
          cmd.cord_step = 1'b1;
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_last) state_nxt = ST_MOVE;
      end
      ST_MOVE: begin
        cmd.move_step = 1'b1;
        if (sts.move_last) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`include "fly_camera_orientation_step_unit_assert.svh"
  `FCS_ASSERT_IMP(a_fire_idle, in_fire, state_r == ST_IDLE)
  `FCS_ASSERT_NXT(a_load_next, cmd.load, state_r == ST_ANGLE)
  `FCS_ASSERT_IMP(a_out_once, cmd.out_load, !out_busy && state_r == ST_OUT)
endmodule

### sv/fcs_datapath.sv
// Angles, CORDIC, shared multiplier and position registers
module fcs_datapath
  import fcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  fcs_cmd_t           cmd,
  output fcs_sts_t           sts,
  input  logic signed [15:0] yaw_delta,
  input  logic signed [15:0] pitch_delta,
  input  logic [2:0]         move_dir,
  input  logic [15:0]        frame_time,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [31:0]        cfg_val,
  output logic signed [31:0] pos_o [3],
  output logic signed [15:0] vec_o [9]
);
  logic [15:0]        speed_r;
  logic signed [15:0] yd_r, pd_r;
  logic [2:0]         dir_r;
  logic [15:0]        ft_r;
  logic [16:0]        yaw_r;
  logic signed [15:0] pitch_r;
  logic signed [31:0] pos_r [3];
  logic signed [15:0] vec_r [9];
  logic signed [15:0] sy_r, cy_r, sp_r, cp_r;
  logic signed [31:0] cx_r, cyv_r;
  logic signed [25:0] cz_r;
  logic               flip_r;
  logic [3:0]         it_r;
  logic [2:0]         mcnt_r;
  logic [1:0]         kcnt_r;
  logic [31:0]        spd_r;

  // angle update
  logic signed [18:0] ysum, ywrap;
  logic signed [17:0] psum, pcl;
  always_comb begin
    ysum = $signed({2'b00, yaw_r}) + 19'(yd_r);
    if (ysum < 0) ywrap = ysum + 19'(YAW_FULL);
    else if (ysum >= 19'(YAW_FULL)) ywrap = ysum - 19'(YAW_FULL);
    else ywrap = ysum;
    psum = 18'(pitch_r) + 18'(pd_r);
    if (psum > 18'(PITCH_LIMIT)) pcl = 18'(PITCH_LIMIT);
    else if (psum < -18'(PITCH_LIMIT)) pcl = -18'(PITCH_LIMIT);
    else pcl = psum;
  end

  // CORDIC seed for a Q.8 angle in [-180,180); yaw seeds from the new angle
  logic signed [18:0] ang_in, ang_red;
  logic               flip_in;
  always_comb begin
    ang_in = cmd.cord_start_p ? 19'(pitch_r)
           : (ywrap >= 19'(HALF_TURN) ? ywrap - 19'(YAW_FULL) : ywrap);
    flip_in = 1'b0;
    ang_red = ang_in;
    if (ang_in > 19'(QUARTER_TURN)) begin
      ang_red = ang_in - 19'(HALF_TURN); flip_in = 1'b1;
    end else if (ang_in < -19'(QUARTER_TURN)) begin
      ang_red = ang_in + 19'(HALF_TURN); flip_in = 1'b1;
    end
  end

  logic signed [31:0] dx, dy;
  logic signed [25:0] at;
  assign dx = cyv_r >>> it_r;
  assign dy = cx_r >>> it_r;
  assign at = 26'(atan_deg16(it_r));

  // round Q2.30 to Q1.14, clamp and unflip
  function automatic logic signed [15:0] cfin(input logic signed [31:0] v,
                                              input logic f);
    logic signed [16:0] r;
    logic signed [15:0] c;
    r = 17'((33'(v) + 33'sd32768) >>> 16);
    if (r > 17'(VEC_ONE)) c = 16'(VEC_ONE);
    else if (r < -17'(VEC_ONE)) c = -16'(VEC_ONE);
    else c = r[15:0];
    cfin = f ? -c : c;
  endfunction

  // shared multiplier
  logic signed [15:0] ma, mb;
  logic signed [31:0] mprod;
  logic signed [15:0] mrnd;
  always_comb begin
    case (mcnt_r)
      3'd0: begin ma = cy_r; mb = cp_r; end
      3'd1: begin ma = sy_r; mb = cp_r; end
      3'd2: begin ma = cy_r; mb = sp_r; end
      default: begin ma = sy_r; mb = sp_r; end
    endcase
    mprod = ma * mb;
    mrnd = 16'((mprod + 32'sd8192) >>> 14);
  end

  // move step: vec (Q1.14) * speed (Q8.24) >> 22
  logic [3:0]         vbase;
  logic               vsub, vmove;
  logic signed [15:0] vsel;
  logic signed [48:0] vprod;
  logic signed [33:0] dstep, pnew;
  logic signed [31:0] psat;
  always_comb begin
    vbase = 4'd0; vsub = 1'b0; vmove = 1'b1;
    case (dir_r)
      DIR_FWD:  vbase = 4'd0;
      DIR_BACK: begin vbase = 4'd0; vsub = 1'b1; end
      DIR_UP:   vbase = 4'd6;
      DIR_DOWN: begin vbase = 4'd6; vsub = 1'b1; end
      DIR_RGT:  vbase = 4'd3;
      DIR_LEFT: begin vbase = 4'd3; vsub = 1'b1; end
      default:  vmove = 1'b0;
    endcase
    vsel = vec_r[vbase + 4'(kcnt_r)];
    vprod = vsel * $signed({1'b0, spd_r});
    dstep = 34'((vprod + 49'sd2097152) >>> 22);
    pnew = vsub ? 34'(pos_r[kcnt_r]) - dstep : 34'(pos_r[kcnt_r]) + dstep;
    if (pnew > 34'sd2147483647) psat = 32'sh7fffffff;
    else if (pnew < -34'sd2147483648) psat = 32'sh80000000;
    else psat = pnew[31:0];
  end

  assign sts.cord_last = (it_r == 4'(TRIG_ITER - 1));
  assign sts.mul_last  = (mcnt_r == 3'd4);
  assign sts.move_last = (kcnt_r == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= 16'd384;
      yaw_r   <= 17'(YAW_RESET);
      pitch_r <= '0;
      for (int k = 0; k < 3; k++) pos_r[k] <= '0;
      vec_r[0] <= '0;
      vec_r[1] <= '0;
      vec_r[2] <= -16'(VEC_ONE);
      vec_r[3] <= 16'(VEC_ONE);
      vec_r[4] <= '0;
      vec_r[5] <= '0;
      vec_r[6] <= '0;
      vec_r[7] <= 16'(VEC_ONE);
      vec_r[8] <= '0;
      it_r <= '0; mcnt_r <= '0; kcnt_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_SPEED: speed_r <= cfg_val[15:0];
          REG_SX:    pos_r[0] <= cfg_val;
          REG_SY:    pos_r[1] <= cfg_val;
          REG_SZ:    pos_r[2] <= cfg_val;
          default: ;
        endcase
      end
      if (cmd.load) begin
        yd_r <= yaw_delta; pd_r <= pitch_delta;
        dir_r <= move_dir; ft_r <= frame_time;
      end
      if (cmd.angle) begin
        yaw_r <= ywrap[16:0];
        pitch_r <= pcl[15:0];
        spd_r <= ft_r * speed_r;
      end
      if (cmd.cord_step) begin
        it_r <= it_r + 4'd1;
        if (cz_r >= 0) begin
          cx_r <= cx_r - dx; cyv_r <= cyv_r + dy; cz_r <= cz_r - at;
        end else begin
          cx_r <= cx_r + dx; cyv_r <= cyv_r - dy; cz_r <= cz_r + at;
        end
      end
      if (cmd.cord_done_y) begin
        cy_r <= cfin(cx_r + (cz_r >= 0 ? -dx : dx), flip_r);
        sy_r <= cfin(cyv_r + (cz_r >= 0 ? dy : -dy), flip_r);
      end
      if (cmd.cord_done_p) begin
        cp_r <= cfin(cx_r + (cz_r >= 0 ? -dx : dx), flip_r);
        sp_r <= cfin(cyv_r + (cz_r >= 0 ? dy : -dy), flip_r);
      end
      if (cmd.cord_start_y || cmd.cord_start_p) begin
        cx_r <= 32'(CORDIC_START);
        cyv_r <= '0;
        cz_r <= 26'(ang_red) <<< 8;
        flip_r <= flip_in;
        it_r <= '0;
        mcnt_r <= '0;
      end
      if (cmd.mul_step) begin
        mcnt_r <= mcnt_r + 3'd1;
        case (mcnt_r)
          3'd0: vec_r[0] <= mrnd;
          3'd1: vec_r[2] <= mrnd;
          3'd2: vec_r[6] <= -mrnd;
          3'd3: vec_r[8] <= -mrnd;
          default: begin
            vec_r[1] <= sp_r; vec_r[3] <= -sy_r; vec_r[4] <= '0;
            vec_r[5] <= cy_r; vec_r[7] <= cp_r;
          end
        endcase
        kcnt_r <= '0;
      end
      if (cmd.move_step) begin
        kcnt_r <= kcnt_r + 2'd1;
        if (vmove) pos_r[kcnt_r] <= psat;
      end
    end
  end

  assign pos_o = pos_r;
  assign vec_o = vec_r;

`include "fly_camera_orientation_step_unit_assert.svh"
  `FCS_ASSERT_IMP(a_yaw_range, 1'b1, yaw_r < 17'(YAW_FULL))
  `FCS_ASSERT_IMP(a_pitch_range, 1'b1,
                  pitch_r <= 16'(PITCH_LIMIT) && pitch_r >= -16'(PITCH_LIMIT))
  `FCS_ASSERT_IMP(a_right_y, cmd.move_step, vec_r[4] == 16'sd0)
endmodule

### sv/fly_camera_orientation_step_unit.sv
// Top level of the fly camera step unit
// One item at a time: an item passes through load, angle update, a yaw and then a
// pitch CORDIC rotation run, the multiply steps, the position steps and the output
// step, in that order, on the single iterative CORDIC shared between yaw and pitch and
// one shared 16x16 multiplier. The result sits in an output register, so the next
// item is taken once the datapath is free even if the result is not yet read.
// A start_x/y/z write also loads that position component.
module fly_camera_orientation_step_unit
  import fcs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // yaw_delta[15:0], pitch_delta[31:16], move_dir[34:32], frame_time[50:35]
  input  logic [55:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x, pos_y, pos_z (32 each), then front_x/y/z, right_x/y/z, up_x/y/z (16 each)
  output logic [239:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  fcs_cmd_t cmd;
  fcs_sts_t sts;
  logic idle, in_fire, out_busy;
  logic signed [31:0] pos [3];
  logic signed [15:0] vec [9];
  logic out_valid_r;
  logic [239:0] out_data_r;

  assign in_tready = idle;
  assign in_fire = in_tvalid && idle;
  assign cfg_ready = 1'b1;
  assign out_busy = out_valid_r && !out_tready;

  fcs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_busy(out_busy),
    .sts(sts), .idle(idle), .cmd(cmd)
  );

  fcs_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .yaw_delta(in_tdata[15:0]), .pitch_delta(in_tdata[31:16]),
    .move_dir(in_tdata[34:32]), .frame_time(in_tdata[50:35]),
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_val(cfg_data),
    .pos_o(pos), .vec_o(vec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load)
      out_data_r <= {vec[8], vec[7], vec[6], vec[5], vec[4], vec[3], vec[2], vec[1],
                     vec[0], pos[2], pos[1], pos[0]};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
endmodule
